FILE: rtl/core/cbs_pkg.sv
// Shared constants, types and codes of the cubic B-spline curve sampler.
// Used by every module under rtl/core. Depends on nothing.

package cbs_pkg;

   // Field widths.
   localparam int CoordBits = 10;
   localparam int FracBits  = 8;
   localparam int OutBits   = 18;
   localparam int ShiftBits = 3;

   // Segments are always evaluated on a grid of 2^MaxShift steps.
   localparam int MaxShift  = 6;
   localparam int KBits     = MaxShift + 1;
   localparam int CubeShift = 3 * MaxShift;
   localparam int WinDepth  = 4;

   // Basis weights are scaled by 6 * 2^CubeShift and sum to exactly that.
   localparam int BasisBits  = $clog2(6 * (1 << CubeShift) + 1);
   localparam int ProdBits   = CoordBits + BasisBits;
   localparam int SumBits    = ProdBits;
   localparam int RoundShift = CubeShift - FracBits;
   localparam int QuotBits   = SumBits - RoundShift + 1;

   // Division by six as a multiply by a rounded-up reciprocal.
   localparam int RecipShift = QuotBits + 3;
   localparam int RecipBits  = RecipShift - 2;
   localparam int MulBits    = QuotBits + RecipBits;
   localparam int VertBits   = QuotBits - 2;
   localparam longint unsigned Recip = ((64'd1 << RecipShift) + 64'd5) / 64'd6;

   localparam logic [KBits-1:0]       SegFull   = KBits'(1 << MaxShift);
   localparam logic [BasisBits:0]     FourCube  = (BasisBits + 1)'(64'd4 << CubeShift);
   localparam logic [BasisBits:0]     SixCube   = (BasisBits + 1)'(64'd6 << CubeShift);
   localparam logic [OutBits-1:0]     OutMax    = '1;
   localparam logic [ShiftBits-1:0]   ShiftCap  = ShiftBits'(MaxShift);
   localparam logic [ShiftBits-1:0]   ShiftInit = ShiftBits'(MaxShift);

   // Depth of the job queue between front and back.
   localparam int JobDepth  = 2;
   localparam int JobPtrBits = $clog2(JobDepth);
   localparam int JobCntBits = $clog2(JobDepth + 1);

   typedef enum logic {
      OpAdd    = 1'b0,
      OpFinish = 1'b1
   } op_type;

   typedef logic [WinDepth-1:0][CoordBits-1:0] window_type;

   // One segment to evaluate: the window snapshot and log2 of its sample count.
   typedef struct packed {
      window_type             win_x;
      window_type             win_y;
      logic [ShiftBits-1:0]   seg_shift;
   } job_type;

endpackage

FILE: rtl/core/cubic_bspline_curve_sampler_core.sv
// Top level of the uniform cubic B-spline curve sampler.
// Depends on cbs_pkg, cbs_front, cbs_job_fifo and cbs_eval.
//
// Use of the block:
//   The req channel carries one item per transfer: req_op selects adding a
//   control point (req_x_in, req_y_in) or a finish command. The rsp channel
//   returns curve vertices with 8 fraction bits; rsp_last_of_run marks the
//   final vertex caused by one item. The csr channel writes step_shift, the
//   log2 of vertices per segment (values above 6 act as 6); write it only
//   while the block is idle.
//   The first point yields one vertex; each later point and each of the two
//   finishes yields 2^step_shift vertices. A finish with no point, or a point
//   after the first finish, yields nothing.
//   Throughput: one vertex per cycle from the single evaluation pipeline,
//   unless a low rsp_ready holds a vertex back. A two-entry job queue lets
//   new items be taken while a segment is emitted.
//   Stalls: while a vertex waits and rsp_ready is low the pipeline holds;
//   req_ready drops once the job queue is full.
//   Reset: the window is empty, step_shift is 6 and no vertex is pending.

module cubic_bspline_curve_sampler_core
   import cbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [CoordBits-1:0] req_x_in,
   input  logic [CoordBits-1:0] req_y_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OutBits-1:0]   rsp_x_out,
   output logic [OutBits-1:0]   rsp_y_out,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ShiftBits-1:0] csr_step_shift
);

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   // Window keeping and job building.
   cbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_step_shift (csr_step_shift),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   // Jobs waiting for the back end.
   cbs_job_fifo u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Vertex evaluation and the result register.
   cbs_eval u_eval (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_out       (rsp_x_out),
      .rsp_y_out       (rsp_y_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/core/cbs_front.sv
// Front end of the sampler: takes control points and finish commands,
// keeps the four-point window and the step register, and queues segment jobs.
// Depends on cbs_pkg.

module cbs_front
   import cbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [CoordBits-1:0] req_x_in,
   input  logic [CoordBits-1:0] req_y_in,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ShiftBits-1:0] csr_step_shift,
   output logic                 push_valid,
   input  logic                 push_ready,
   output job_type              push_job
);

   window_type           win_x_ff, win_x_in;
   window_type           win_y_ff, win_y_in;
   logic                 have_point_ff, have_point_in;
   logic                 finishing_ff, finishing_in;
   logic [ShiftBits-1:0] step_shift_ff;
   logic [ShiftBits-1:0] eff_shift;
   logic                 accept;
   window_type           shift_x, shift_y;

   assign csr_ready = 1'b1;
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign eff_shift = (step_shift_ff > ShiftCap) ? ShiftCap : step_shift_ff;

   // Classify the transfer, update the window and build the job.
   always_comb begin
      win_x_in      = win_x_ff;
      win_y_in      = win_y_ff;
      have_point_in = have_point_ff;
      finishing_in  = finishing_ff;
      push_valid    = 1'b0;
      shift_x       = window_type'({req_x_in, win_x_ff[3], win_x_ff[2], win_x_ff[1]});
      shift_y       = window_type'({req_y_in, win_y_ff[3], win_y_ff[2], win_y_ff[1]});
      if (op_type'(req_op) == OpFinish) begin
         shift_x = window_type'({win_x_ff[3], win_x_ff[3], win_x_ff[2], win_x_ff[1]});
         shift_y = window_type'({win_y_ff[3], win_y_ff[3], win_y_ff[2], win_y_ff[1]});
      end
      push_job.win_x     = shift_x;
      push_job.win_y     = shift_y;
      push_job.seg_shift = eff_shift;

      if (accept) begin
         if (op_type'(req_op) == OpAdd) begin
            if (!finishing_ff) begin
               push_valid = 1'b1;
               if (!have_point_ff) begin
                  // The first point fills the window and yields one vertex.
                  win_x_in           = {WinDepth{req_x_in}};
                  win_y_in           = {WinDepth{req_y_in}};
                  have_point_in      = 1'b1;
                  push_job.win_x     = {WinDepth{req_x_in}};
                  push_job.win_y     = {WinDepth{req_y_in}};
                  push_job.seg_shift = '0;
               end else begin
                  win_x_in = shift_x;
                  win_y_in = shift_y;
               end
            end
         end else if (have_point_ff) begin
            push_valid = 1'b1;
            if (finishing_ff) begin
               // The second finish closes the curve and empties the window.
               win_x_in      = '0;
               win_y_in      = '0;
               have_point_in = 1'b0;
               finishing_in  = 1'b0;
            end else begin
               win_x_in     = shift_x;
               win_y_in     = shift_y;
               finishing_in = 1'b1;
            end
         end
      end
   end

   // Window, progress flags and the step register.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_x_ff      <= '0;
         win_y_ff      <= '0;
         have_point_ff <= 1'b0;
         finishing_ff  <= 1'b0;
         step_shift_ff <= ShiftInit;
      end else begin
         win_x_ff      <= win_x_in;
         win_y_ff      <= win_y_in;
         have_point_ff <= have_point_in;
         finishing_ff  <= finishing_in;
         if (csr_valid && csr_ready) begin
            step_shift_ff <= csr_step_shift;
         end
      end
   end

   // A curve can only be finishing while it holds a point.
   assert property (@(posedge clock) disable iff (reset)
      !have_point_ff |-> !finishing_ff)
      else $error("finishing without a point in the window");

endmodule

FILE: rtl/core/cbs_job_fifo.sv
// Short job queue between the front end and the evaluation back end.
// Depends on cbs_pkg.

module cbs_job_fifo
   import cbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type                 entry_ff [JobDepth];
   logic [JobPtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JobPtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JobCntBits-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != JobCntBits'(JobDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JobPtrBits'(JobDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JobPtrBits'(JobDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // A lone push grows the queue by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

FILE: rtl/core/cbs_eval.sv
// Back end of the sampler: steps through the samples of each queued job and
// evaluates the B-spline blend in a stalling pipeline ending in the result register.
// Depends on cbs_pkg.

module cbs_eval
   import cbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  job_type            pop_job,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OutBits-1:0] rsp_x_out,
   output logic [OutBits-1:0] rsp_y_out,
   output logic               rsp_last_of_run
);

   // Sample sequencer.
   logic               busy_ff, busy_in;
   logic [KBits-1:0]   cnt_ff, cnt_in;
   job_type            job_ff, job_in;
   logic [KBits-1:0]   seg_len;
   logic [KBits-1:0]   k_issue;
   logic               is_last;
   logic               issue;
   logic               adv;

   // Pipeline valids and last flags.
   logic [7:1]         valid_ff;
   logic [7:1]         last_ff;
   logic               rsp_valid_ff;

   // Stage payloads.
   logic [KBits-1:0]       s1_k_ff;
   window_type             s1_wx_ff, s1_wy_ff;
   logic [KBits-1:0]       s1_r;
   logic [2*KBits-1:0]     s2_k2_in, s2_r2_in;
   logic [KBits-1:0]       s2_k_ff, s2_r_ff;
   logic [2*KBits-1:0]     s2_k2_ff, s2_r2_ff;
   window_type             s2_wx_ff, s2_wy_ff;
   logic [3*KBits-1:0]     s3_k3_in, s3_r3_in;
   logic [2*KBits-1:0]     s3_k2_ff;
   logic [BasisBits-1:0]   s3_k3_ff, s3_r3_ff;
   window_type             s3_wx_ff, s3_wy_ff;
   logic [BasisBits:0]     k3_wide, k2_wide, b1_wide, b2_wide;
   logic [WinDepth-1:0][BasisBits-1:0] s4_b_in, s4_b_ff;
   window_type             s4_wx_ff, s4_wy_ff;
   logic [WinDepth-1:0][ProdBits-1:0]  s5_px_in, s5_py_in, s5_px_ff, s5_py_ff;
   logic [SumBits-1:0]     sum_x, sum_y;
   logic [QuotBits-1:0]    s6_qx_in, s6_qy_in, s6_qx_ff, s6_qy_ff;
   logic [MulBits-1:0]     mul_x, mul_y;
   logic [VertBits-1:0]    s7_vx_ff, s7_vy_ff;
   logic [OutBits-1:0]     rsp_x_in, rsp_y_in, rsp_x_ff, rsp_y_ff;
   logic                   rsp_last_ff;

   // The whole pipeline moves when the result register can take a value.
   assign adv = !rsp_valid_ff || rsp_ready;

   // Walk k = 1 .. 2^shift and map it onto the fixed 2^MaxShift grid.
   always_comb begin
      seg_len   = KBits'(1) << job_ff.seg_shift;
      is_last   = (cnt_ff == seg_len);
      issue     = busy_ff && adv;
      pop_ready = !busy_ff || (issue && is_last);
      k_issue   = cnt_ff << (ShiftCap - job_ff.seg_shift);
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      job_in    = job_ff;
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         cnt_in  = KBits'(1);
         job_in  = pop_job;
      end else if (issue && is_last) begin
         busy_in = 1'b0;
      end else if (issue) begin
         cnt_in = cnt_ff + KBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= KBits'(1);
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // Squares, then cubes, of k and of 2^MaxShift - k.
   always_comb begin
      s1_r     = SegFull - s1_k_ff;
      s2_k2_in = (2*KBits)'(s1_k_ff) * (2*KBits)'(s1_k_ff);
      s2_r2_in = (2*KBits)'(s1_r) * (2*KBits)'(s1_r);
      s3_k3_in = (3*KBits)'(s2_k2_ff) * (3*KBits)'(s2_k_ff);
      s3_r3_in = (3*KBits)'(s2_r2_ff) * (3*KBits)'(s2_r_ff);
   end

   // Basis weights; the third follows from the weights summing to SixCube.
   always_comb begin
      k3_wide = (BasisBits + 1)'(s3_k3_ff);
      k2_wide = (BasisBits + 1)'(s3_k2_ff);
      b1_wide = (k3_wide << 1) + k3_wide + FourCube
              - (((k2_wide << 2) + (k2_wide << 1)) << MaxShift);
      b2_wide = SixCube - (BasisBits + 1)'(s3_r3_ff) - b1_wide - k3_wide;
      s4_b_in[0] = s3_r3_ff;
      s4_b_in[1] = b1_wide[BasisBits-1:0];
      s4_b_in[2] = b2_wide[BasisBits-1:0];
      s4_b_in[3] = s3_k3_ff;
   end

   // Weighted coordinates, one lane per window entry.
   always_comb begin
      for (int i = 0; i < WinDepth; i++) begin
         s5_px_in[i] = ProdBits'(s4_wx_ff[i]) * ProdBits'(s4_b_ff[i]);
         s5_py_in[i] = ProdBits'(s4_wy_ff[i]) * ProdBits'(s4_b_ff[i]);
      end
   end

   // Sum, drop the extra fraction bits and add the rounding offset.
   always_comb begin
      sum_x    = s5_px_ff[0] + s5_px_ff[1] + s5_px_ff[2] + s5_px_ff[3];
      sum_y    = s5_py_ff[0] + s5_py_ff[1] + s5_py_ff[2] + s5_py_ff[3];
      s6_qx_in = QuotBits'(sum_x >> RoundShift) + QuotBits'(3);
      s6_qy_in = QuotBits'(sum_y >> RoundShift) + QuotBits'(3);
   end

   // Divide by six through the reciprocal, then saturate.
   always_comb begin
      mul_x    = MulBits'(s6_qx_ff) * MulBits'(Recip);
      mul_y    = MulBits'(s6_qy_ff) * MulBits'(Recip);
      rsp_x_in = (s7_vx_ff > VertBits'(OutMax)) ? OutMax : OutBits'(s7_vx_ff);
      rsp_y_in = (s7_vy_ff > VertBits'(OutMax)) ? OutMax : OutBits'(s7_vy_ff);
   end

   // Stage valids and the result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[6:1], issue};
         rsp_valid_ff <= valid_ff[7];
      end
   end

   // Stage payloads move with the valids.
   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff     <= {last_ff[6:1], is_last};
         rsp_last_ff <= last_ff[7];
         s1_k_ff     <= k_issue;
         s1_wx_ff    <= job_ff.win_x;
         s1_wy_ff    <= job_ff.win_y;
         s2_k_ff     <= s1_k_ff;
         s2_r_ff     <= s1_r;
         s2_k2_ff    <= s2_k2_in;
         s2_r2_ff    <= s2_r2_in;
         s2_wx_ff    <= s1_wx_ff;
         s2_wy_ff    <= s1_wy_ff;
         s3_k2_ff    <= s2_k2_ff;
         s3_k3_ff    <= BasisBits'(s3_k3_in);
         s3_r3_ff    <= BasisBits'(s3_r3_in);
         s3_wx_ff    <= s2_wx_ff;
         s3_wy_ff    <= s2_wy_ff;
         s4_b_ff     <= s4_b_in;
         s4_wx_ff    <= s3_wx_ff;
         s4_wy_ff    <= s3_wy_ff;
         s5_px_ff    <= s5_px_in;
         s5_py_ff    <= s5_py_in;
         s6_qx_ff    <= s6_qx_in;
         s6_qy_ff    <= s6_qy_in;
         s7_vx_ff    <= mul_x[RecipShift +: VertBits];
         s7_vy_ff    <= mul_y[RecipShift +: VertBits];
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // The sample counter stays within the current segment.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0) && (cnt_ff <= seg_len))
      else $error("sample counter outside its segment");

   // The final sample of every segment lands on the end of the grid.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && last_ff[1] |-> s1_k_ff == SegFull)
      else $error("last sample not at the segment end");

   // The second basis weight never exceeds its value at the segment start.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (BasisBits + 1)'(s4_b_ff[1]) <= FourCube)
      else $error("basis weight out of range");

endmodule
